// ===== design/ght_pkg.sv =====
// Shared types and constants for the generational handle table.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package ght_pkg;

  // Table geometry and field widths.
  localparam int SLOT_COUNT = 1024;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int GEN_W      = 16;
  localparam int TAG_W      = 16;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;

  // Item commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_t;

  // One slot of the table.
  typedef struct packed {
    logic             alloc;
    logic [TAG_W-1:0] tag;
    logic [GEN_W-1:0] gen;
  } slot_entry_t;

  // One free stack entry: the freed index and the generation it now holds.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } stack_entry_t;

endpackage

// ===== design/ght_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/ght_ctrl.sv =====
// Controller for the generational handle table: sequences one item at a time
// and owns the handshakes. Depends on ght_pkg.
`timescale 1ns / 1ps

module ght_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ght_pkg::ctl_t ctl
);

  import ght_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  // State and result valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An item is taken only when the result register is free by the next edge.
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // Next state and datapath commands.
  always_comb begin
    state_nxt   = state_r;
    ctl.capture = 1'b0;
    ctl.execute = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ctl.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.execute = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The result register fills on execute and empties when taken.
  always_comb begin
    if (ctl.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/ght_dp.sv =====
// Datapath for the generational handle table: slot memory, free stack memory,
// counters, handle check and result register. Depends on ght_pkg and ght_ram.
`timescale 1ns / 1ps

module ght_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ght_pkg::ctl_t                ctl,
  input  logic [ght_pkg::CMD_W-1:0]    in_command,
  input  logic [ght_pkg::IDX_W-1:0]    in_handle_index,
  input  logic [ght_pkg::GEN_W-1:0]    in_handle_generation,
  input  logic [ght_pkg::TAG_W-1:0]    in_tag_value,
  output logic [ght_pkg::STATUS_W-1:0] out_status,
  output logic [ght_pkg::IDX_W-1:0]    out_slot_index,
  output logic [ght_pkg::GEN_W-1:0]    out_slot_generation
);

  import ght_pkg::*;

  // Captured item.
  logic [CMD_W-1:0] cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic [GEN_W-1:0] gen_r;
  logic [TAG_W-1:0] tag_r;

  // High-water count and free stack depth.
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] depth_r, depth_nxt;

  // Result register.
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic [GEN_W-1:0]    res_gen_r, res_gen_nxt;

  // Memory ports.
  logic         slot_we;
  logic [IDX_W-1:0] slot_waddr, slot_raddr;
  slot_entry_t  slot_wdata, slot_rdata;
  logic         stk_we;
  logic [IDX_W-1:0] stk_waddr, stk_raddr;
  stack_entry_t stk_wdata, stk_rdata;

  logic             live;
  logic [GEN_W-1:0] gen_inc;
  logic [GEN_W-1:0] gen_next;

  // Capture the item as it is accepted.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_command;
      idx_r <= in_handle_index;
      gen_r <= in_handle_generation;
      tag_r <= in_tag_value;
    end
  end

  // Read addresses: allocate looks at the next fresh slot, others at the handle.
  assign slot_raddr = (cmd_t'(in_command) == CMD_ALLOC) ? count_r[IDX_W-1:0]
                                                         : in_handle_index;
  assign stk_raddr  = IDX_W'(depth_r - CNT_W'(1));

  ght_ram #(
    .WIDTH($bits(slot_entry_t)),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (slot_we),
    .wr_addr(slot_waddr),
    .wr_data(slot_wdata),
    .rd_en  (ctl.capture),
    .rd_addr(slot_raddr),
    .rd_data(slot_rdata)
  );

  ght_ram #(
    .WIDTH($bits(stack_entry_t)),
    .DEPTH(SLOT_COUNT)
  ) u_stack_ram (
    .clk    (clk),
    .wr_en  (stk_we),
    .wr_addr(stk_waddr),
    .wr_data(stk_wdata),
    .rd_en  (ctl.capture),
    .rd_addr(stk_raddr),
    .rd_data(stk_rdata)
  );

  // A handle is live when its slot was handed out and matches exactly.
  assign live = ({1'b0, idx_r} < count_r) && slot_rdata.alloc &&
                (slot_rdata.gen == gen_r) && (slot_rdata.tag == tag_r);

  // Generation advance wraps and skips zero.
  assign gen_inc  = gen_r + GEN_W'(1);
  assign gen_next = (gen_inc == '0) ? GEN_W'(1) : gen_inc;

  // Execute the captured command.
  always_comb begin
    count_nxt   = count_r;
    depth_nxt   = depth_r;
    status_nxt  = status_r;
    res_idx_nxt = res_idx_r;
    res_gen_nxt = res_gen_r;
    slot_we     = 1'b0;
    slot_waddr  = idx_r;
    slot_wdata  = '0;
    stk_we      = 1'b0;
    stk_waddr   = depth_r[IDX_W-1:0];
    stk_wdata   = '{idx: idx_r, gen: gen_next};
    if (ctl.execute) begin
      status_nxt  = STATUS_INVALID;
      res_idx_nxt = '0;
      res_gen_nxt = '0;
      unique case (cmd_t'(cmd_r))
        CMD_ALLOC: begin
          if (depth_r != '0) begin
            // Reuse the most recently freed slot; its generation rides along.
            depth_nxt   = depth_r - CNT_W'(1);
            slot_we     = 1'b1;
            slot_waddr  = stk_rdata.idx;
            slot_wdata  = '{alloc: 1'b1, tag: tag_r, gen: stk_rdata.gen};
            status_nxt  = STATUS_OK;
            res_idx_nxt = stk_rdata.idx;
            res_gen_nxt = stk_rdata.gen;
          end else if (count_r < CNT_W'(SLOT_COUNT)) begin
            // A fresh slot starts at generation zero.
            count_nxt   = count_r + CNT_W'(1);
            slot_we     = 1'b1;
            slot_waddr  = count_r[IDX_W-1:0];
            slot_wdata  = '{alloc: 1'b1, tag: tag_r, gen: '0};
            status_nxt  = STATUS_OK;
            res_idx_nxt = count_r[IDX_W-1:0];
          end else begin
            status_nxt = STATUS_FULL;
          end
        end
        CMD_CHECK: begin
          if (live) begin
            status_nxt = STATUS_OK;
          end
        end
        CMD_FREE: begin
          if (live) begin
            slot_we    = 1'b1;
            slot_wdata = '{alloc: 1'b0, tag: '0, gen: gen_next};
            if (depth_r < CNT_W'(SLOT_COUNT)) begin
              stk_we    = 1'b1;
              depth_nxt = depth_r + CNT_W'(1);
            end
            status_nxt = STATUS_OK;
          end
        end
        default: begin
          status_nxt = STATUS_INVALID;
        end
      endcase
    end
  end

  // Counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      depth_r <= '0;
    end else begin
      count_r <= count_nxt;
      depth_r <= depth_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    res_idx_r <= res_idx_nxt;
    res_gen_r <= res_gen_nxt;
  end

  assign out_status          = status_r;
  assign out_slot_index      = res_idx_r;
  assign out_slot_generation = res_gen_r;

endmodule

// ===== design/generational_handle_table_top.sv =====
// Top level of the generational handle table: joins controller and datapath.
// Depends on ght_pkg, ght_ctrl, ght_dp and ght_ram.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one command item: allocate,
//   check handle or free handle, with the handle index, handle generation and
//   tag. The result channel (out_valid/out_ready) returns exactly one item per
//   input: a status, and the slot index and generation on a good allocate.
//   The block first reads the slot memory and the free stack top, then
//   decides and writes back; it takes no new item before the result of the
//   last one is in its output register.
//   Items are handled one at a time; a new item is taken while the previous
//   result is being taken in the same cycle.
//   Reset (rst_n low, synchronous) empties the table: the high-water count and
//   the free stack depth go to zero, so no memory clearing pass is needed.
//   If the receiver stalls, the result holds in its output register and
//   in_ready stays low until the result is taken.
`timescale 1ns / 1ps

module generational_handle_table_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ght_pkg::CMD_W-1:0]    in_command,
  input  logic [ght_pkg::IDX_W-1:0]    in_handle_index,
  input  logic [ght_pkg::GEN_W-1:0]    in_handle_generation,
  input  logic [ght_pkg::TAG_W-1:0]    in_tag_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ght_pkg::STATUS_W-1:0] out_status,
  output logic [ght_pkg::IDX_W-1:0]    out_slot_index,
  output logic [ght_pkg::GEN_W-1:0]    out_slot_generation
);

  import ght_pkg::*;

  ctl_t ctl;

  // Sequencer and handshakes.
  ght_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ctl      (ctl)
  );

  // Table storage and item processing.
  ght_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .in_command          (in_command),
    .in_handle_index     (in_handle_index),
    .in_handle_generation(in_handle_generation),
    .in_tag_value        (in_tag_value),
    .out_status          (out_status),
    .out_slot_index      (out_slot_index),
    .out_slot_generation (out_slot_generation)
  );

endmodule

// ===== design/ght_checker.sv =====
// Port-level checker for the generational handle table, bound to the top level.
// Depends on ght_pkg and generational_handle_table_top.
`timescale 1ns / 1ps

module ght_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ght_pkg::STATUS_W-1:0] out_status,
  input logic [ght_pkg::IDX_W-1:0]    out_slot_index,
  input logic [ght_pkg::GEN_W-1:0]    out_slot_generation
);

  import ght_pkg::*;

  // A stalled result keeps its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_slot_index) && $stable(out_slot_generation))
    else $error("result changed while stalled");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("item overlap after accept");

  // Every accepted item produces its result once the execute state has run.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  // Status is a defined code, and failures carry zero index and generation.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_OK) |->
    (out_status == STATUS_FULL || out_status == STATUS_INVALID) &&
    (out_slot_index == '0) && (out_slot_generation == '0))
    else $error("bad failure result");

endmodule

bind generational_handle_table_top ght_checker u_ght_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_slot_index     (out_slot_index),
  .out_slot_generation(out_slot_generation)
);
